[rtl/lcag_pkg.sv]
// Shared types and constants for the life grid core.
// Holds the opcode set, the register indexes and the B3/S23 rule counts.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lcag_pkg;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 7'd64;

    // Neighbor counts of the rule
    localparam logic [3:0] BIRTH_COUNT  = 4'd3;
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;

endpackage

`default_nettype wire

[rtl/lcag_mem.sv]
// Two-bank grid memory: one row of cells per entry, one bank current, one next.
// One write port and one read port, read data registered. Uses lcag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcag_mem
    import lcag_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rd_en,
    input  wire logic                        i_rd_bank,
    input  wire logic [$clog2(MAX_ROWS)-1:0] i_rd_addr,
    output logic      [MAX_COLS-1:0]         o_rd_data,
    input  wire logic                        i_wr_en,
    input  wire logic                        i_wr_bank,
    input  wire logic [$clog2(MAX_ROWS)-1:0] i_wr_addr,
    input  wire logic [MAX_COLS-1:0]         i_wr_data
);

    logic [MAX_COLS-1:0] r_mem [0:1][0:MAX_ROWS-1];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_bank][i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_bank][i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/lcag_row_eval.sv]
// Next-generation row from a three-row window, one B3/S23 cell per column.
// Inputs arrive with unused columns already cleared. Uses lcag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcag_row_eval
    import lcag_pkg::*;
#(
    parameter int MAX_COLS = 64
) (
    input  wire logic [MAX_COLS-1:0] i_above,
    input  wire logic [MAX_COLS-1:0] i_mid,
    input  wire logic [MAX_COLS-1:0] i_below,
    input  wire logic [MAX_COLS-1:0] i_col_mask,
    input  wire logic                i_row_live,
    output logic      [MAX_COLS-1:0] o_next
);

    logic [MAX_COLS+1:0] w_above;
    logic [MAX_COLS+1:0] w_mid;
    logic [MAX_COLS+1:0] w_below;
    logic [MAX_COLS-1:0] w_rule;

    // Pad one dead cell at each edge
    assign w_above = {1'b0, i_above, 1'b0};
    assign w_mid   = {1'b0, i_mid, 1'b0};
    assign w_below = {1'b0, i_below, 1'b0};

    always_comb begin
        logic [3:0] n;
        for (int c = 0; c < MAX_COLS; c++) begin
            n = 4'(w_above[c]) + 4'(w_above[c+1]) + 4'(w_above[c+2])
              + 4'(w_mid[c]) + 4'(w_mid[c+2])
              + 4'(w_below[c]) + 4'(w_below[c+1]) + 4'(w_below[c+2]);
            if (i_mid[c]) begin
                w_rule[c] = (n >= SURVIVE_LOW) && (n <= SURVIVE_HIGH);
            end else begin
                w_rule[c] = (n == BIRTH_COUNT);
            end
        end
    end

    assign o_next = i_row_live ? (w_rule & i_col_mask) : '0;

endmodule

`default_nettype wire

[rtl/life_cellular_automaton_grid_core.sv]
// Top level of the life grid core: handshakes, size registers and sequencer.
// Instantiates lcag_mem and lcag_row_eval; uses lcag_pkg.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_opcode, i_row_index,   | sink
//          | i_col_index, i_cell_value                        |
//  out     | o_out_valid, i_out_stall, o_cell_alive,          | source
//          | o_range_error                                    |
//  cfg     | i_cfg_wr_en, i_cfg_index, i_cfg_data             | sink
//
// A cell read or write goes through memory read, modify/write back, then result.
// During a generation step the sweep reads one row per cycle through the single
// read port and writes one finished row per cycle.
// After reset a clearing pass zeroes every row of the current bank; no beat is
// taken meanwhile. Beats are taken only while the sequencer is idle; a result
// held by a stalled output blocks only the completion of the following item.
`timescale 1ns / 1ps
`default_nettype none

module life_cellular_automaton_grid_core
    import lcag_pkg::*;
#(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [5:0]            i_row_index,
    input  wire logic [5:0]            i_col_index,
    input  wire logic                  i_cell_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_cell_alive,
    output logic                       o_range_error,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int UR_W  = $clog2(MAX_ROWS + 1);
    localparam int CW    = (UR_W > CFG_DATA_W) ? UR_W : CFG_DATA_W;
    localparam int IW    = (ROW_W > 6) ? ROW_W : 6;

    localparam logic [UR_W-1:0] LAST_DROW = UR_W'(MAX_ROWS);
    localparam logic [UR_W-1:0] LAST_ROW  = UR_W'(MAX_ROWS - 1);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_ACC  = 5'b00100,
        S_STEP = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_DATA_W-1:0] r_col_count;
    logic [CFG_DATA_W-1:0] r_row_count;
    logic                  r_bank;
    logic [UR_W-1:0]       r_cnt;
    logic [UR_W-1:0]       r_drow;
    logic                  r_dv;
    logic [MAX_COLS-1:0]   r_above;
    logic [MAX_COLS-1:0]   r_mid;

    t_opcode               r_op;
    logic                  r_err;
    logic [ROW_W-1:0]      r_row_addr;
    logic [COL_W-1:0]      r_col;
    logic                  r_val;
    logic                  r_pend_alive;
    logic                  r_pend_err;
    logic                  r_out_valid;
    logic                  r_out_alive;
    logic                  r_out_err;

    logic                  w_in_fire;
    logic                  w_out_free;
    logic [CW-1:0]         w_used_rows_cw;
    logic [UR_W-1:0]       w_used_rows;
    logic [CFG_DATA_W-1:0] w_used_cols;
    logic [MAX_COLS-1:0]   w_col_mask;
    logic [IW-1:0]         w_row_ext;
    logic                  w_in_err;
    logic                  w_step_exit;
    logic [UR_W-1:0]       w_wrow;
    logic [MAX_COLS-1:0]   w_below;
    logic [MAX_COLS-1:0]   w_next_row;

    logic                  w_rd_en;
    logic [ROW_W-1:0]      w_rd_addr;
    logic [MAX_COLS-1:0]   w_rd_data;
    logic                  w_wr_en;
    logic                  w_wr_bank;
    logic [ROW_W-1:0]      w_wr_addr;
    logic [MAX_COLS-1:0]   w_wr_data;

    // Size in use, clamped to 1..max
    always_comb begin
        if (r_row_count == '0) begin
            w_used_rows_cw = CW'(1);
        end else if (CW'(r_row_count) > CW'(MAX_ROWS)) begin
            w_used_rows_cw = CW'(MAX_ROWS);
        end else begin
            w_used_rows_cw = CW'(r_row_count);
        end
        if (r_col_count == '0) begin
            w_used_cols = CFG_DATA_W'(1);
        end else if (r_col_count > CFG_DATA_W'(MAX_COLS)) begin
            w_used_cols = CFG_DATA_W'(MAX_COLS);
        end else begin
            w_used_cols = r_col_count;
        end
    end

    assign w_used_rows = UR_W'(w_used_rows_cw);

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            w_col_mask[c] = CFG_DATA_W'(c) < w_used_cols;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_fire  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_row_ext  = IW'(i_row_index);
    assign w_in_err   = (CW'(i_row_index) >= w_used_rows_cw)
                     || ({1'b0, i_col_index} >= w_used_cols);

    // Step window: the row arriving now is the lower neighbor of row r_drow - 1
    assign w_below     = (r_drow < w_used_rows) ? (w_rd_data & w_col_mask) : '0;
    assign w_wrow      = r_drow - UR_W'(1);
    assign w_step_exit = r_dv && (r_drow == LAST_DROW);

    lcag_row_eval #(
        .MAX_COLS (MAX_COLS)
    ) u_row_eval (
        .i_above    (r_above),
        .i_mid      (r_mid),
        .i_below    (w_below),
        .i_col_mask (w_col_mask),
        .i_row_live (w_wrow < w_used_rows),
        .o_next     (w_next_row)
    );

    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = w_row_ext[ROW_W-1:0];
        w_wr_en   = 1'b0;
        w_wr_bank = r_bank;
        w_wr_addr = r_row_addr;
        w_wr_data = w_rd_data;
        unique case (r_state)
            S_CLR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_cnt[ROW_W-1:0];
                w_wr_data = '0;
            end
            S_IDLE: begin
                w_rd_en = w_in_fire;
            end
            S_ACC: begin
                w_wr_en          = (r_op == OP_WRITE) && !r_err;
                w_wr_data[r_col] = r_val;
            end
            S_STEP: begin
                w_rd_en   = (r_cnt != LAST_DROW);
                w_rd_addr = r_cnt[ROW_W-1:0];
                w_wr_en   = r_dv && (r_drow != '0);
                w_wr_bank = !r_bank;
                w_wr_addr = w_wrow[ROW_W-1:0];
                w_wr_data = w_next_row;
            end
            S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    lcag_mem #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_bank (r_bank),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_bank (w_wr_bank),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_cnt == LAST_ROW) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (t_opcode'(i_opcode) == OP_STEP) ? S_STEP : S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_FIN;
            end
            S_STEP: begin
                if (w_step_exit) n_state = S_FIN;
            end
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_col_count <= COUNT_RESET;
            r_row_count <= COUNT_RESET;
            r_bank      <= 1'b0;
            r_cnt       <= '0;
            r_drow      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_COL_COUNT: r_col_count <= i_cfg_data;
                    CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                S_CLR: begin
                    r_cnt <= (r_cnt == LAST_ROW) ? '0 : r_cnt + UR_W'(1);
                end
                S_IDLE: begin
                    r_cnt <= '0;
                    r_dv  <= 1'b0;
                end
                S_STEP: begin
                    if (r_cnt != LAST_DROW) r_cnt <= r_cnt + UR_W'(1);
                    // Track the row whose read data arrives next cycle
                    r_drow <= r_cnt;
                    r_dv   <= !w_step_exit;
                    // Swap banks once the last row is written
                    if (w_step_exit) r_bank <= !r_bank;
                end
                S_ACC, S_FIN: begin
                end
                default: begin
                end
            endcase

            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op         <= t_opcode'(i_opcode);
            r_err        <= w_in_err && (t_opcode'(i_opcode) == OP_WRITE
                                      || t_opcode'(i_opcode) == OP_READ);
            r_row_addr   <= w_row_ext[ROW_W-1:0];
            r_col        <= i_col_index[COL_W-1:0];
            r_val        <= i_cell_value;
            r_above      <= '0;
            r_mid        <= '0;
            r_pend_alive <= 1'b0;
            r_pend_err   <= 1'b0;
        end
        if (r_state == S_ACC) begin
            r_pend_alive <= (r_op == OP_READ) && !r_err && w_rd_data[r_col];
            r_pend_err   <= r_err;
        end
        if (r_state == S_STEP && r_dv) begin
            r_above <= r_mid;
            r_mid   <= w_below;
        end
        if (r_state == S_FIN && w_out_free) begin
            r_out_alive <= r_pend_alive;
            r_out_err   <= r_pend_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_alive  = r_out_alive;
    assign o_range_error = r_out_err;

endmodule

`default_nettype wire
